/* hw/rtl/dvc_pkg.sv */
// shared constants and types for the dotted version comparator
package dvc_pkg;

   // default sizing
   localparam int MAX_FIELDS_DEF = 16;
   localparam int VALUE_BITS_DEF = 32;

   // character codes
   localparam logic [7:0] CH_DOT  = 8'h2E;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;

   // status codes, higher code wins
   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_FIELDS = 2'd1;
   localparam logic [1:0] STATUS_SAT    = 2'd2;
   localparam logic [1:0] STATUS_BADCH  = 2'd3;

   // order codes
   localparam logic signed [1:0] ORDER_OLDER = -2'sd1;
   localparam logic signed [1:0] ORDER_EQUAL = 2'sd0;
   localparam logic signed [1:0] ORDER_NEWER = 2'sd1;

   // control from the sequencer to the field accumulator
   typedef struct packed {
      logic step_digit;
      logic clear;
   } acc_ctrl_type;

endpackage

/* hw/rtl/dvc_field_mem.sv */
// field store of the first version: one write port, two registered read ports
module dvc_field_mem #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32,
   parameter int AW    = 4
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_a,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read ports with write-first bypass
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr_a)) begin
         rd_a_ff <= wr_data;
      end else begin
         rd_a_ff <= mem_ff[rd_addr_a];
      end
      if (wr_en && (wr_addr == rd_addr_b)) begin
         rd_b_ff <= wr_data;
      end else begin
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

/* hw/rtl/dvc_field_acc.sv */
// decimal field accumulator with saturation
module dvc_field_acc #(
   parameter int VALUE_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dvc_pkg::acc_ctrl_type  ctrl,
   input  logic [3:0]             digit,
   output logic [VALUE_BITS-1:0]  field_value,
   output logic                   saturate
);
   import dvc_pkg::*;

   localparam int WB = VALUE_BITS + 4;

   logic [VALUE_BITS-1:0] acc_ff;
   logic [VALUE_BITS-1:0] acc_in;
   logic [WB-1:0]         acc_ext;
   logic [WB-1:0]         acc_sum;
   logic                  over;

   // acc * 10 + digit as shifts and adds
   always_comb begin
      acc_ext = {4'b0000, acc_ff};
      acc_sum = (acc_ext << 3) + (acc_ext << 1) + {{(WB-4){1'b0}}, digit};
      over    = |acc_sum[WB-1:VALUE_BITS];
   end

   // value of the field including this character
   always_comb begin
      if (!ctrl.step_digit) begin
         field_value = acc_ff;
      end else if (over) begin
         field_value = '1;
      end else begin
         field_value = acc_sum[VALUE_BITS-1:0];
      end
      saturate = ctrl.step_digit && over;
      acc_in   = ctrl.clear ? '0 : field_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

endmodule

/* hw/rtl/dotted_version_compare.sv */
// dotted version comparator: one character per cycle unless stalled, from the first cycle after reset
// result is registered: it shows the cycle after the transfer of the final character of the second string
// field values sit in a two-read-port memory, prefetched at the current and next field index
// reset is synchronous: counters, verdict, status and output valid clear; the field memory is not
// cleared, reads beyond the count of written fields give zero
module dotted_version_compare #(
   parameter int MAX_FIELDS = dvc_pkg::MAX_FIELDS_DEF,
   parameter int VALUE_BITS = dvc_pkg::VALUE_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_which_string,
   input  logic [7:0]        req_ch,
   input  logic              req_last,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic signed [1:0] rsp_order,
   output logic [1:0]        rsp_status
);
   import dvc_pkg::*;

   localparam int CW = $clog2(MAX_FIELDS + 1);
   localparam int IW = $clog2(MAX_FIELDS);
   localparam logic [CW-1:0] MAX_C = CW'(MAX_FIELDS);
   localparam logic [CW-1:0] ONE_C = CW'(1);

   // state registers
   logic [CW-1:0]         first_count_ff,   first_count_in;
   logic [CW-1:0]         written_count_ff, written_count_in;
   logic [CW-1:0]         nonzero_ff,       nonzero_in;
   logic [CW-1:0]         second_index_ff,  second_index_in;
   logic                  verdict_set_ff,   verdict_set_in;
   logic signed [1:0]     verdict_ff,       verdict_in;
   logic [1:0]            error_ff,         error_in;
   logic                  first_done_ff,    first_done_in;
   logic                  rsp_valid_ff,     rsp_valid_in;
   logic signed [1:0]     rsp_order_ff;
   logic [1:0]            rsp_status_ff;

   // datapath signals
   logic                  accept;
   logic                  step;
   logic                  is_digit;
   logic                  is_dot;
   logic                  is_bad;
   logic                  closing;
   logic                  dual_close;
   acc_ctrl_type          acc_ctrl;
   logic [VALUE_BITS-1:0] field_value;
   logic                  acc_sat;
   logic                  wr_en;
   logic [VALUE_BITS-1:0] rd_a;
   logic [VALUE_BITS-1:0] rd_b;
   logic [VALUE_BITS-1:0] other_a;
   logic [VALUE_BITS-1:0] other_b;
   logic [CW-1:0]         count_a;
   logic [CW-1:0]         index_a;
   logic [CW-1:0]         index_next_p1;
   logic                  load_result;
   logic signed [1:0]     order_result;

   function automatic logic [1:0] status_max(input logic [1:0] a, input logic [1:0] b);
      return (b > a) ? b : a;
   endfunction

   // handshake: hold a result-producing character only while the output is blocked
   assign req_stall = rsp_valid_ff && rsp_stall && req_which_string && first_done_ff
                      && req_last;
   assign accept    = req_valid && !req_stall;
   assign step      = accept && (req_which_string == first_done_ff);

   // character classes
   assign is_digit   = (req_ch >= CH_ZERO) && (req_ch <= CH_NINE);
   assign is_dot     = (req_ch == CH_DOT);
   assign is_bad     = !is_digit && !is_dot;
   assign closing    = is_dot || req_last;
   assign dual_close = is_dot && req_last;

   assign acc_ctrl.step_digit = step && is_digit;
   assign acc_ctrl.clear      = step && closing;

   dvc_field_acc #(
      .VALUE_BITS (VALUE_BITS)
   ) u_acc (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (acc_ctrl),
      .digit       (req_ch[3:0]),
      .field_value (field_value),
      .saturate    (acc_sat)
   );

   assign index_next_p1 = second_index_in + ONE_C;

   dvc_field_mem #(
      .DEPTH (MAX_FIELDS),
      .WIDTH (VALUE_BITS),
      .AW    (IW)
   ) u_mem (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (first_count_ff[IW-1:0]),
      .wr_data   (field_value),
      .rd_addr_a (second_index_in[IW-1:0]),
      .rd_addr_b (index_next_p1[IW-1:0]),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   // stored fields of the first string, zero beyond the written ones
   assign other_a = (second_index_ff < written_count_ff) ? rd_a : '0;
   assign other_b = ((second_index_ff < MAX_C) && ((second_index_ff + ONE_C) < written_count_ff))
                    ? rd_b : '0;

   // per-character sequencing
   always_comb begin
      first_count_in   = first_count_ff;
      written_count_in = written_count_ff;
      nonzero_in       = nonzero_ff;
      second_index_in  = second_index_ff;
      verdict_set_in   = verdict_set_ff;
      verdict_in       = verdict_ff;
      error_in         = error_ff;
      first_done_in    = first_done_ff;
      wr_en            = 1'b0;
      count_a          = first_count_ff;
      index_a          = second_index_ff;
      load_result      = 1'b0;
      order_result     = ORDER_EQUAL;

      if (step) begin
         if (acc_sat) begin
            error_in = status_max(error_in, STATUS_SAT);
         end
         if (is_bad) begin
            error_in = status_max(error_in, STATUS_BADCH);
         end

         if (!req_which_string) begin
            // first string: store closed fields
            if (closing) begin
               if (first_count_ff < MAX_C) begin
                  wr_en            = 1'b1;
                  count_a          = first_count_ff + ONE_C;
                  written_count_in = count_a;
                  if (field_value != '0) begin
                     nonzero_in = count_a;
                  end
               end else begin
                  error_in = status_max(error_in, STATUS_FIELDS);
               end
               first_count_in = count_a;
               // trailing separator closes an extra empty field
               if (dual_close) begin
                  if (count_a < MAX_C) begin
                     first_count_in = count_a + ONE_C;
                  end else begin
                     error_in = status_max(error_in, STATUS_FIELDS);
                  end
               end
            end
            if (req_last) begin
               first_done_in = 1'b1;
            end
         end else begin
            // second string: compare closed fields
            if (closing) begin
               if (!verdict_set_in) begin
                  if (other_a > field_value) begin
                     verdict_set_in = 1'b1;
                     verdict_in     = ORDER_NEWER;
                  end else if (other_a < field_value) begin
                     verdict_set_in = 1'b1;
                     verdict_in     = ORDER_OLDER;
                  end
               end
               if (second_index_ff < MAX_C) begin
                  index_a = second_index_ff + ONE_C;
               end else begin
                  error_in = status_max(error_in, STATUS_FIELDS);
               end
               second_index_in = index_a;
               if (dual_close) begin
                  if (!verdict_set_in && (other_b != '0)) begin
                     verdict_set_in = 1'b1;
                     verdict_in     = ORDER_NEWER;
                  end
                  if (index_a < MAX_C) begin
                     second_index_in = index_a + ONE_C;
                  end else begin
                     error_in = status_max(error_in, STATUS_FIELDS);
                  end
               end
            end
            // end of the pair: emit and start over
            if (req_last) begin
               load_result = 1'b1;
               if (verdict_set_in) begin
                  order_result = verdict_in;
               end else if (nonzero_ff > second_index_in) begin
                  order_result = ORDER_NEWER;
               end else begin
                  order_result = ORDER_EQUAL;
               end
               first_count_in   = '0;
               written_count_in = '0;
               nonzero_in       = '0;
               second_index_in  = '0;
               verdict_set_in   = 1'b0;
               verdict_in       = ORDER_EQUAL;
               first_done_in    = 1'b0;
            end
         end
      end
   end

   // status for the result is taken before clearing
   logic [1:0] status_result;
   assign status_result = error_in;

   // output register
   assign rsp_valid_in = load_result || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         first_count_ff   <= '0;
         written_count_ff <= '0;
         nonzero_ff       <= '0;
         second_index_ff  <= '0;
         verdict_set_ff   <= 1'b0;
         verdict_ff       <= ORDER_EQUAL;
         error_ff         <= STATUS_OK;
         first_done_ff    <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         first_count_ff   <= first_count_in;
         written_count_ff <= written_count_in;
         nonzero_ff       <= nonzero_in;
         second_index_ff  <= second_index_in;
         verdict_set_ff   <= verdict_set_in;
         verdict_ff       <= verdict_in;
         error_ff         <= load_result ? STATUS_OK : error_in;
         first_done_ff    <= first_done_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (load_result) begin
         rsp_order_ff  <= order_result;
         rsp_status_ff <= status_result;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_order  = rsp_order_ff;
   assign rsp_status = rsp_status_ff;

   // written fields never run past the field count, and the field count never runs past MAX_FIELDS
   assert property (@(posedge clock) disable iff (reset)
      (written_count_ff <= first_count_ff) && (first_count_ff <= MAX_C))
      else $error("field counts out of range");

   // nonzero extent stays within the written fields
   assert property (@(posedge clock) disable iff (reset)
      nonzero_ff <= written_count_ff)
      else $error("nonzero extent beyond written fields");

   // a result always returns the comparator to its start state
   assert property (@(posedge clock) disable iff (reset)
      load_result |=> (!first_done_ff && (first_count_ff == '0) && (error_ff == STATUS_OK)))
      else $error("state not cleared after result");

   // the output register is loaded only when it is free or draining
   assert property (@(posedge clock) disable iff (reset)
      load_result |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwrote a stalled output");

endmodule

/* verif/dotted_version_compare_tb.sv */
// self-checking testbench for the dotted version comparator
module dotted_version_compare_tb;
   import dvc_pkg::*;

   localparam int FIELD_LIMIT = MAX_FIELDS_DEF;
   localparam int VALUE_WIDTH = VALUE_BITS_DEF;
   localparam logic [63:0] FIELD_MAX = (64'd1 << VALUE_WIDTH) - 64'd1;
   localparam int RANDOM_CHARS = 1800;

   typedef struct {
      logic signed [1:0] order;
      logic [1:0]        status;
   } version_result_type;

   typedef string field_list_type[$];

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic              req_which_string;
   logic [7:0]        req_ch;
   logic              req_last;
   logic              rsp_valid;
   logic              rsp_stall;
   logic signed [1:0] rsp_order;
   logic [1:0]        rsp_status;

   // state of the comparison as the block should hold it
   logic [VALUE_WIDTH-1:0] stored_fields[FIELD_LIMIT];
   logic [4:0]             stored_count;
   logic [4:0]             nonzero_reach;
   logic [VALUE_WIDTH-1:0] field_acc;
   logic [4:0]             second_pos;
   bit                     order_found;
   logic signed [1:0]      order_seen;
   logic [1:0]             status_seen;
   bit                     first_ended;

   version_result_type results_due[$];
   int unsigned        error_count = 0;
   int unsigned        chars_sent = 0;
   bit                 gaps_on = 0;

   dotted_version_compare #(
      .MAX_FIELDS(FIELD_LIMIT),
      .VALUE_BITS(VALUE_WIDTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_which_string(req_which_string),
      .req_ch(req_ch),
      .req_last(req_last),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_order(rsp_order),
      .rsp_status(rsp_status)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("dotted_version_compare_tb: FAIL");
      $finish;
   end

   task automatic report(input string what);
      error_count++;
      $display("mismatch at %0t: %s", $time, what);
   endtask

   function void clear_tracker();
      stored_count = '0;
      nonzero_reach = '0;
      field_acc = '0;
      second_pos = '0;
      order_found = 1'b0;
      order_seen = ORDER_EQUAL;
      status_seen = STATUS_OK;
      first_ended = 1'b0;
   endfunction

   function void raise_status(input logic [1:0] code);
      if (code > status_seen) status_seen = code;
   endfunction

   function void close_first_field();
      if (stored_count < FIELD_LIMIT) begin
         stored_fields[stored_count] = field_acc;
         stored_count++;
         if (field_acc != '0) nonzero_reach = stored_count;
      end else begin
         raise_status(STATUS_FIELDS);
      end
      field_acc = '0;
   endfunction

   function void close_second_field();
      logic [VALUE_WIDTH-1:0] other;
      other = (second_pos < stored_count) ? stored_fields[second_pos] : '0;
      // first difference decides
      if (!order_found) begin
         if (other > field_acc) begin
            order_seen = ORDER_NEWER;
            order_found = 1'b1;
         end else if (other < field_acc) begin
            order_seen = ORDER_OLDER;
            order_found = 1'b1;
         end
      end
      if (second_pos < FIELD_LIMIT) second_pos++;
      else raise_status(STATUS_FIELDS);
      field_acc = '0;
   endfunction

   // update the tracked state for one accepted character
   function void track_char(input logic which, input logic [7:0] ch, input logic last);
      logic [63:0]        digit;
      version_result_type res;
      if (which != first_ended) return;
      if (ch >= CH_ZERO && ch <= CH_NINE) begin
         digit = 64'(ch - CH_ZERO);
         if (64'(field_acc) > (FIELD_MAX - digit) / 64'd10) begin
            field_acc = '1;
            raise_status(STATUS_SAT);
         end else begin
            field_acc = VALUE_WIDTH'(64'(field_acc) * 64'd10 + digit);
         end
      end else if (ch == CH_DOT) begin
         if (which) close_second_field();
         else close_first_field();
      end else begin
         raise_status(STATUS_BADCH);
      end
      if (!last) return;
      if (!which) begin
         close_first_field();
         first_ended = 1'b1;
         return;
      end
      close_second_field();
      if (order_found) res.order = order_seen;
      else res.order = (nonzero_reach > second_pos) ? ORDER_NEWER : ORDER_EQUAL;
      res.status = status_seen;
      results_due = {results_due, res};
      clear_tracker();
   endfunction

   // send one character and wait for its transfer
   task automatic send_char(input logic which, input logic [7:0] ch, input logic last);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_which_string <= which;
      req_ch <= ch;
      req_last <= last;
      do @(posedge clock); while (req_stall !== 1'b0);
      chars_sent++;
      track_char(which, ch, last);
   endtask

   task automatic send_text(input logic which, input string txt, input int noise);
      int i;
      for (i = 0; i < txt.len(); i++) begin
         if ($urandom_range(0, 99) < noise) send_char(which, 8'($urandom), 1'b0);
         send_char(which, txt[i], i == txt.len() - 1);
      end
   endtask

   task automatic send_pair(input string first_txt, input string second_txt);
      send_text(1'b0, first_txt, 0);
      send_text(1'b1, second_txt, 0);
   endtask

   // hold the sender until every pending result has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_due.size() != 0) @(posedge clock);
   endtask

   // result side: random stall bursts
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (gaps_on && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // compare each result transfer with the oldest pending one
   always @(posedge clock) begin
      version_result_type due;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (results_due.size() == 0) begin
            report("result with nothing pending");
         end else begin
            due = results_due.pop_front();
            if (rsp_order !== due.order)
               report($sformatf("order %0d, expected %0d", rsp_order, due.order));
            if (rsp_status !== due.status)
               report($sformatf("status %0d, expected %0d", rsp_status, due.status));
         end
      end
   end

   task automatic test_plain_order();
      send_pair("1.2", "1.10");
      send_pair("2", "1.9");
      send_pair("1.0", "1");
   endtask

   task automatic test_empty_fields();
      send_pair(".5", "0.5");
      send_pair("1.", "1");
      send_pair("1..2", "1.0.2");
   endtask

   task automatic test_leftover_field();
      send_pair("1.0.3", "1");
      send_pair("1", "1.0.0");
   endtask

   task automatic test_bad_char();
      send_pair("1a", "1");
      send_char(1'b0, 8'h00, 1'b0);
      send_char(1'b0, 8'hFF, 1'b0);
      send_char(1'b0, 8'h2F, 1'b1);
      send_char(1'b1, 8'h3A, 1'b1);
   endtask

   task automatic test_saturation();
      send_pair("4294967295", "4294967295");
      send_pair("99999999999", "4294967296");
   endtask

   task automatic test_field_limit();
      string many;
      // seventeen empty fields in the first string
      send_pair("................", "1");
      // seventeen fields in the second string, the last one nonzero
      many = "";
      repeat (FIELD_LIMIT) many = {many, "0."};
      many = {many, "7"};
      send_pair("1", many);
   endtask

   task automatic test_out_of_order();
      send_char(1'b1, "5", 1'b1);
      send_char(1'b0, "1", 1'b1);
      send_char(1'b0, "7", 1'b1);
      send_char(1'b1, "2", 1'b1);
   endtask

   function automatic string rand_field();
      string s;
      int    n;
      case ($urandom_range(0, 9))
         0: s = "";
         1, 2, 3, 4: s = $sformatf("%0d", $urandom_range(0, 3));
         5: s = $sformatf("%0d", $urandom_range(0, 99));
         6: s = $sformatf("0%0d", $urandom_range(0, 9));
         7: s = $sformatf("%0d", $urandom);
         8: s = $urandom_range(0, 1) ? "4294967295" : "4294967296";
         default: begin
            n = $urandom_range(10, 14);
            s = "";
            repeat (n) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
         end
      endcase
      return s;
   endfunction

   function automatic string join_fields(input field_list_type fields);
      string s;
      int    i;
      s = fields[0];
      for (i = 1; i < fields.size(); i++) s = {s, ".", fields[i]};
      if (s.len() == 0) s = "0";
      return s;
   endfunction

   // one random pair, the second string mostly a variation of the first
   task automatic rand_pair();
      field_list_type first_f;
      field_list_type second_f;
      int             nf;
      int             keep;
      int             noise;
      nf = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 5);
      repeat (nf) first_f = {first_f, rand_field()};
      second_f = first_f;
      case ($urandom_range(0, 5))
         0: ;
         1: second_f[$urandom_range(0, second_f.size() - 1)] = rand_field();
         2: repeat ($urandom_range(1, 3))
               second_f = {second_f, ($urandom_range(0, 1) ? "0" : rand_field())};
         3: begin
            keep = $urandom_range(1, second_f.size());
            while (second_f.size() > keep) void'(second_f.pop_back());
         end
         default: begin
            second_f.delete();
            repeat ($urandom_range(1, 5)) second_f = {second_f, rand_field()};
         end
      endcase
      noise = ($urandom_range(0, 7) == 0) ? 10 : 0;
      // stray characters on the wrong string are ignored
      if ($urandom_range(0, 9) == 0) send_char(1'b1, 8'($urandom), 1'($urandom));
      send_text(1'b0, join_fields(first_f), noise);
      if ($urandom_range(0, 9) == 0) send_char(1'b0, 8'($urandom), 1'($urandom));
      send_text(1'b1, join_fields(second_f), noise);
   endtask

   task automatic test_random();
      int unsigned stop_at;
      int unsigned quiet_at;
      stop_at = chars_sent + RANDOM_CHARS;
      quiet_at = chars_sent + RANDOM_CHARS * 9 / 10;
      while (chars_sent < quiet_at) begin
         gaps_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 15) == 0) wait_for_results();
         rand_pair();
      end
      // closing stretch at full rate
      wait_for_results();
      gaps_on = 1'b0;
      while (chars_sent < stop_at) rand_pair();
   endtask

   // main sequence
   initial begin
      clear_tracker();
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_which_string <= 1'b0;
      req_ch <= 8'h00;
      req_last <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_plain_order();
      test_empty_fields();
      test_leftover_field();
      test_bad_char();
      test_saturation();
      test_field_limit();
      test_out_of_order();
      test_random();
      req_valid <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("dotted_version_compare_tb: PASS");
      end else begin
         $display("dotted_version_compare_tb: FAIL");
      end
      $finish;
   end

endmodule
